// File: hw/rtl/tdkl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdkl_pkg
// shared types, token codes, keyword tables and character classifier for the
// keyword lexer
// ----------------------------------------------------------------------------
package tdkl_pkg;

   localparam int MAX_LEXEME_DEFAULT = 32;
   localparam int QUEUE_DEPTH        = 4;
   localparam int NUM_KEYWORDS       = 4;
   localparam int KW_MAX_CHARS       = 8;

   typedef enum logic [3:0] {
      SCAN_IDLE  = 4'd0,
      SCAN_IDENT = 4'd1,
      SCAN_CONST = 4'd3,
      SCAN_COLON = 4'd11
   } scan_state_type;

   typedef enum logic [3:0] {
      KIND_ID       = 4'd0,
      KIND_INICIO   = 4'd1,
      KIND_FIN      = 4'd2,
      KIND_LEER     = 4'd3,
      KIND_ESCRIBIR = 4'd4,
      KIND_CONST    = 4'd5,
      KIND_PLUS     = 4'd6,
      KIND_MINUS    = 4'd7,
      KIND_LPAREN   = 4'd8,
      KIND_RPAREN   = 4'd9,
      KIND_COMMA    = 4'd10,
      KIND_SEMI     = 4'd11,
      KIND_ASSIGN   = 4'd12,
      KIND_END      = 4'd13,
      KIND_ERROR    = 4'd14
   } kind_type;

   typedef enum logic [2:0] {
      CC_LETTER,
      CC_DIGIT,
      CC_SPACE,
      CC_COLON,
      CC_EQUALS,
      CC_OTHER
   } char_class_type;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // keyword spellings, zero padded
   localparam logic [7:0] KW_CHARS [NUM_KEYWORDS][KW_MAX_CHARS] = '{
      '{8'h69, 8'h6E, 8'h69, 8'h63, 8'h69, 8'h6F, 8'h00, 8'h00},
      '{8'h66, 8'h69, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6C, 8'h65, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h65, 8'h73, 8'h63, 8'h72, 8'h69, 8'h62, 8'h69, 8'h72}
   };
   localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{4'd6, 4'd3, 4'd4, 4'd8};
   localparam kind_type KW_KIND [NUM_KEYWORDS] =
      '{KIND_INICIO, KIND_FIN, KIND_LEER, KIND_ESCRIBIR};

   typedef struct packed {
      kind_type    kind;
      logic [31:0] start;
      logic [5:0]  length;
      logic        overflow;
      logic        last;
   } tok_type;

   // up to two tokens written into the queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      tok_type    tok0;
      tok_type    tok1;
   } push_type;

   typedef struct packed {
      logic    valid;
      tok_type tok;
   } head_type;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cls;
      if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
         cls = CC_LETTER;
      end else if (c inside {[8'h30:8'h39]}) begin
         cls = CC_DIGIT;
      end else if (c inside {[8'h09:8'h0D], CH_SPACE}) begin
         cls = CC_SPACE;
      end else if (c == CH_COLON) begin
         cls = CC_COLON;
      end else if (c == CH_EQUALS) begin
         cls = CC_EQUALS;
      end else begin
         cls = CC_OTHER;
      end
      return cls;
   endfunction

   // single character tokens; anything else is an error token
   function automatic kind_type punct_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_MINUS;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_COMMA:  k = KIND_COMMA;
         CH_SEMI:   k = KIND_SEMI;
         default:   k = KIND_ERROR;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tdkl_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdkl_req_if
// request channel: one character or an end-of-text mark
// ----------------------------------------------------------------------------
interface tdkl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tdkl_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdkl_rsp_if
// response channel: one token per transfer
// ----------------------------------------------------------------------------
interface tdkl_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [31:0] lexeme_start;
   logic [5:0]  lexeme_length;
   logic        overflow;
   logic        last;

   modport source (output valid, output token_kind, output lexeme_start,
                   output lexeme_length, output overflow, output last, input ready);
   modport sink (input valid, input token_kind, input lexeme_start,
                 input lexeme_length, input overflow, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tdkl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdkl_front
// scanner automaton: classifies each character, tracks the pending lexeme and
// its keyword matches, and pushes zero, one or two tokens per request
// ----------------------------------------------------------------------------
module tdkl_front #(
   parameter int MAX_LEXEME = tdkl_pkg::MAX_LEXEME_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   tdkl_req_if.sink            req_chan,
   input  wire                 q_room,
   output tdkl_pkg::push_type  push
);

   localparam int CW = $clog2(MAX_LEXEME + 1);

   tdkl_pkg::scan_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           over_ff, over_in;
   logic [31:0]    start_ff, start_in;
   logic [31:0]    pos_ff, pos_in;
   logic [tdkl_pkg::NUM_KEYWORDS-1:0] kw_ok_ff, kw_ok_in;

   logic                     accept;
   logic [7:0]               c;
   tdkl_pkg::char_class_type cls;
   tdkl_pkg::kind_type       id_kind;
   logic                     flush_v, sec_v, rescan, append;
   tdkl_pkg::tok_type        flush_tok, sec_tok;

   assign req_chan.ready = q_room;
   assign accept         = req_chan.valid && req_chan.ready;
   assign c              = req_chan.char_code;
   assign cls            = tdkl_pkg::classify(c);

   // keyword lookup on the pending identifier, first match wins
   always_comb begin
      id_kind = tdkl_pkg::KIND_ID;
      for (int k = tdkl_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
         if (kw_ok_ff[k] && !over_ff && count_ff == CW'(tdkl_pkg::KW_LEN[k])) begin
            id_kind = tdkl_pkg::KW_KIND[k];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      over_in  = over_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      kw_ok_in = kw_ok_ff;
      flush_v  = 1'b0;
      sec_v    = 1'b0;
      rescan   = 1'b0;
      append   = 1'b0;

      flush_tok.kind     = tdkl_pkg::KIND_ERROR;
      flush_tok.start    = start_ff;
      flush_tok.length   = 6'(count_ff);
      flush_tok.overflow = over_ff;
      flush_tok.last     = 1'b0;
      case (state_ff)
         tdkl_pkg::SCAN_IDENT: flush_tok.kind = id_kind;
         tdkl_pkg::SCAN_CONST: flush_tok.kind = tdkl_pkg::KIND_CONST;
         default:              flush_tok.kind = tdkl_pkg::KIND_ERROR;
      endcase

      sec_tok.kind     = tdkl_pkg::punct_kind(c);
      sec_tok.start    = pos_ff;
      sec_tok.length   = 6'd1;
      sec_tok.overflow = 1'b0;
      sec_tok.last     = 1'b0;

      if (accept) begin
         if (req_chan.end_of_text) begin
            flush_v        = (state_ff != tdkl_pkg::SCAN_IDLE);
            sec_v          = 1'b1;
            sec_tok.kind   = tdkl_pkg::KIND_END;
            sec_tok.length = 6'd0;
            state_in       = tdkl_pkg::SCAN_IDLE;
            count_in       = '0;
            over_in        = 1'b0;
         end else begin
            pos_in = pos_ff + 32'd1;
            case (state_ff)
               tdkl_pkg::SCAN_IDENT: begin
                  if (cls == tdkl_pkg::CC_LETTER || cls == tdkl_pkg::CC_DIGIT) begin
                     append = 1'b1;
                  end else begin
                     flush_v = 1'b1;
                     rescan  = 1'b1;
                  end
               end
               tdkl_pkg::SCAN_CONST: begin
                  if (cls == tdkl_pkg::CC_DIGIT) begin
                     append = 1'b1;
                  end else begin
                     flush_v = 1'b1;
                     rescan  = 1'b1;
                  end
               end
               tdkl_pkg::SCAN_COLON: begin
                  if (cls == tdkl_pkg::CC_EQUALS) begin
                     sec_v          = 1'b1;
                     sec_tok.kind   = tdkl_pkg::KIND_ASSIGN;
                     sec_tok.start  = start_ff;
                     sec_tok.length = 6'd2;
                     state_in       = tdkl_pkg::SCAN_IDLE;
                     count_in       = '0;
                     over_in        = 1'b0;
                  end else begin
                     flush_v = 1'b1;
                     rescan  = 1'b1;
                  end
               end
               default: rescan = 1'b1;
            endcase

            if (append) begin
               if (count_ff < CW'(MAX_LEXEME)) begin
                  count_in = count_ff + CW'(1);
                  for (int k = 0; k < tdkl_pkg::NUM_KEYWORDS; k++) begin
                     kw_ok_in[k] = kw_ok_ff[k]
                        && (count_ff < CW'(tdkl_pkg::KW_LEN[k]))
                        && (c == tdkl_pkg::KW_CHARS[k][count_ff[2:0]]);
                  end
               end else begin
                  over_in = 1'b1;
               end
            end

            if (rescan) begin
               state_in = tdkl_pkg::SCAN_IDLE;
               count_in = '0;
               over_in  = 1'b0;
               case (cls)
                  tdkl_pkg::CC_LETTER, tdkl_pkg::CC_DIGIT, tdkl_pkg::CC_COLON: begin
                     start_in = pos_ff;
                     count_in = CW'(1);
                     for (int k = 0; k < tdkl_pkg::NUM_KEYWORDS; k++) begin
                        kw_ok_in[k] = (c == tdkl_pkg::KW_CHARS[k][0]);
                     end
                     if (cls == tdkl_pkg::CC_LETTER) begin
                        state_in = tdkl_pkg::SCAN_IDENT;
                     end else if (cls == tdkl_pkg::CC_DIGIT) begin
                        state_in = tdkl_pkg::SCAN_CONST;
                     end else begin
                        state_in = tdkl_pkg::SCAN_COLON;
                     end
                  end
                  tdkl_pkg::CC_SPACE: ;
                  default: sec_v = 1'b1;
               endcase
            end
         end
      end

      // pack tokens in emit order, mark the final one
      push.count     = {1'b0, flush_v} + {1'b0, sec_v};
      push.tok0      = flush_v ? flush_tok : sec_tok;
      push.tok0.last = !(flush_v && sec_v);
      push.tok1      = sec_tok;
      push.tok1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdkl_pkg::SCAN_IDLE;
         count_ff <= '0;
         over_ff  <= 1'b0;
         start_ff <= '0;
         pos_ff   <= '0;
         kw_ok_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         over_ff  <= over_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         kw_ok_ff <= kw_ok_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/tdkl_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdkl_queue
// short token queue between scanner and output stage, two writes and one
// read per cycle
// ----------------------------------------------------------------------------
module tdkl_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  tdkl_pkg::push_type  push,
   input  wire                 pop,
   output tdkl_pkg::head_type  head,
   output logic                q_room
);

   localparam int QD   = tdkl_pkg::QUEUE_DEPTH;
   localparam int AW   = $clog2(QD);
   localparam int CNTW = $clog2(QD + 1);

   tdkl_pkg::tok_type mem_ff [QD];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [AW-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + AW'(1);
   assign wr_ptr_in   = wr_ptr_ff + AW'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + AW'(pop);
   assign count_in    = count_ff + CNTW'(push.count) - CNTW'(pop);

   assign head.valid = (count_ff != '0);
   assign head.tok   = mem_ff[rd_ptr_ff];
   assign q_room     = (count_ff <= CNTW'(QD - 2));

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(QD))
      else $error("token queue count beyond depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("token queue read while empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (CNTW'(push.count) <= CNTW'(QD) - count_ff))
      else $error("token queue written beyond free space");

endmodule
`default_nettype wire

// File: hw/rtl/tdkl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdkl_back
// output stage: takes tokens from the queue and holds them on the response
// channel until taken
// ----------------------------------------------------------------------------
module tdkl_back (
   input  wire                 clock,
   input  wire                 reset,
   input  tdkl_pkg::head_type  head,
   output logic                pop,
   tdkl_rsp_if.source          rsp_chan
);

   logic              valid_ff, valid_in;
   tdkl_pkg::tok_type tok_ff;

   assign pop      = head.valid && (!valid_ff || rsp_chan.ready);
   assign valid_in = pop || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         tok_ff <= head.tok;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.token_kind    = tok_ff.kind;
   assign rsp_chan.lexeme_start  = tok_ff.start;
   assign rsp_chan.lexeme_length = tok_ff.length;
   assign rsp_chan.overflow      = tok_ff.overflow;
   assign rsp_chan.last          = tok_ff.last;

endmodule
`default_nettype wire

// File: hw/rtl/table_driven_keyword_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// table_driven_keyword_lexer
// character-at-a-time lexer with keyword lookup, four-token queue and
// registered token output
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ------------------------------------------
//  req_chan  in   valid/ready        char_code[7:0], end_of_text
//  rsp_chan  out  valid/ready        token_kind[3:0], lexeme_start[31:0],
//                                    lexeme_length[5:0], overflow, last
//
//  a request is taken every cycle while the token queue has room for two
//  tokens; scanning and keyword compare finish in the accepting cycle
//  a request makes zero, one or two tokens; the output stage sends one token
//  per cycle while rsp_chan.ready is high, so two-token requests fill the queue
//  a token passes the queue and the output register before rsp_chan shows it
//  synchronous reset returns the scanner to idle, position zero, queue empty
//  a stalled response fills the queue, then req_chan.ready drops
//
module table_driven_keyword_lexer #(
   parameter int MAX_LEXEME = tdkl_pkg::MAX_LEXEME_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   tdkl_req_if.sink    req_chan,
   tdkl_rsp_if.source  rsp_chan
);

   // scanner to queue
   tdkl_pkg::push_type push;
   logic               q_room;

   // queue to output stage
   tdkl_pkg::head_type head;
   logic               pop;

   // front: automaton, lexeme length and keyword match tracking
   tdkl_front #(
      .MAX_LEXEME (MAX_LEXEME)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_room   (q_room),
      .push     (push)
   );

   // decoupling queue, absorbs the second token of a request
   tdkl_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .q_room (q_room)
   );

   // back: registered response stage
   tdkl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
